### design/led_color_frame_parser_defines.svh
// assertion macros for the led color frame parser
// included by the top level; no other dependencies
`ifndef LED_COLOR_FRAME_PARSER_DEFINES_SVH
`define LED_COLOR_FRAME_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

`define LCFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcfp assertion failed");

`define LCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcfp assertion failed");

`else

`define LCFP_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define LCFP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/lcfp_pkg.sv
// shared constants and types for the led color frame parser
// no dependencies; used by lcfp_decode and the top level
`default_nettype none

package lcfp_pkg;

   // default range sizes
   localparam int PANEL_COUNT_DEFAULT  = 16;
   localparam int EFFECT_COUNT_DEFAULT = 8;
   localparam int MODE_COUNT_DEFAULT   = 8;

   // address range bases
   localparam logic [6:0] ADDR_EFFECT_BASE = 7'd100;
   localparam logic [6:0] ADDR_MODE_BASE   = 7'd120;

   // parser phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_ADDR  = 3'd1;
   localparam logic [2:0] PH_RED   = 3'd2;
   localparam logic [2:0] PH_GREEN = 3'd3;
   localparam logic [2:0] PH_BLUE  = 3'd4;
   localparam logic [2:0] PH_WHITE = 3'd5;

   // write targets
   localparam logic [1:0] TGT_PANEL  = 2'd0;
   localparam logic [1:0] TGT_EFFECT = 2'd1;
   localparam logic [1:0] TGT_MODE   = 2'd2;

   typedef struct packed {
      logic       hit;
      logic [1:0] target;
      logic [3:0] slot;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] white;
   } lcfp_result_type;

endpackage

`default_nettype wire

### design/lcfp_decode.sv
// address range decode and channel reassembly for a completed frame
// depends on lcfp_pkg
`default_nettype none

module lcfp_decode #(
   parameter int PANEL_COUNT  = lcfp_pkg::PANEL_COUNT_DEFAULT,
   parameter int EFFECT_COUNT = lcfp_pkg::EFFECT_COUNT_DEFAULT,
   parameter int MODE_COUNT   = lcfp_pkg::MODE_COUNT_DEFAULT
) (
   input  wire logic [6:0]               address,
   input  wire logic [6:0]               red7,
   input  wire logic [6:0]               green7,
   input  wire logic [6:0]               blue7,
   input  wire logic [6:0]               white7,
   input  wire logic [3:0]               top_bits,
   output lcfp_pkg::lcfp_result_type     result
);
   import lcfp_pkg::*;

   localparam logic [7:0] PanelLimit  = 8'(PANEL_COUNT);
   localparam logic [7:0] EffectLow   = {1'b0, ADDR_EFFECT_BASE};
   localparam logic [7:0] EffectLimit = 8'(int'(ADDR_EFFECT_BASE) + EFFECT_COUNT);
   localparam logic [7:0] ModeLow     = {1'b0, ADDR_MODE_BASE};
   localparam logic [7:0] ModeLimit   = 8'(int'(ADDR_MODE_BASE) + MODE_COUNT);

   logic [7:0] addr_ext;
   logic [6:0] effect_off;
   logic [6:0] mode_off;
   logic       in_panel;
   logic       in_effect;
   logic       in_mode;

   assign addr_ext   = {1'b0, address};
   assign effect_off = address - ADDR_EFFECT_BASE;
   assign mode_off   = address - ADDR_MODE_BASE;
   assign in_panel   = addr_ext < PanelLimit;
   assign in_effect  = (addr_ext >= EffectLow) && (addr_ext < EffectLimit);
   assign in_mode    = (addr_ext >= ModeLow) && (addr_ext < ModeLimit);

   always_comb begin
      result.hit    = 1'b1;
      result.target = TGT_PANEL;
      result.slot   = address[3:0];
      result.red    = {top_bits[0], red7};
      result.green  = {top_bits[1], green7};
      result.blue   = {top_bits[2], blue7};
      result.white  = {top_bits[3], white7};
      if (in_panel) begin
         result.target = TGT_PANEL;
      end else if (in_effect) begin
         result.target = TGT_EFFECT;
         result.slot   = effect_off[3:0];
      end else if (in_mode) begin
         // mode select carries no color
         result.target = TGT_MODE;
         result.slot   = mode_off[3:0];
         result.red    = '0;
         result.green  = '0;
         result.blue   = '0;
         result.white  = '0;
      end else begin
         result.hit = 1'b0;
      end
   end

endmodule

`default_nettype wire

### design/led_color_frame_parser.sv
// led color frame parser
// accepts one request byte per cycle on req_ (valid/ready). frames are six bytes:
// an address byte with bit 7 set, red, green, blue, white (7 bits each) and a
// trailer whose upper nibble is zero and whose low bits are the channel msbs.
// a byte with bit 7 set restarts the frame as a new address.
// a completed frame whose address falls in the panel, effect or mode range
// produces one write on rsp_ (valid/ready); other frames produce nothing.
// the write appears on rsp_ in the cycle after the trailer is accepted.
// throughput: one byte per cycle while req_ready is high, set by the single parser state register.
// the output register stays loaded while rsp_ready is low, and req_ready drops
// only while a write is held there and the receiver stalls it.
// reset (synchronous, active high) returns the parser to idle and empties
// the output register.
// depends on lcfp_pkg, lcfp_decode and led_color_frame_parser_defines.svh
`default_nettype none
`include "led_color_frame_parser_defines.svh"

module led_color_frame_parser #(
   parameter int PANEL_COUNT  = lcfp_pkg::PANEL_COUNT_DEFAULT,
   parameter int EFFECT_COUNT = lcfp_pkg::EFFECT_COUNT_DEFAULT,
   parameter int MODE_COUNT   = lcfp_pkg::MODE_COUNT_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_target,
   output logic [3:0]      rsp_slot,
   output logic [7:0]      rsp_red,
   output logic [7:0]      rsp_green,
   output logic [7:0]      rsp_blue,
   output logic [7:0]      rsp_white
);
   import lcfp_pkg::*;

   logic [2:0]      phase_ff, phase_in;
   logic [6:0]      address_ff, address_in;
   logic [6:0]      red_ff, red_in;
   logic [6:0]      green_ff, green_in;
   logic [6:0]      blue_ff, blue_in;
   logic [6:0]      white_ff, white_in;
   logic            rsp_valid_ff, rsp_valid_in;
   lcfp_result_type rsp_ff, rsp_in;

   lcfp_result_type dec;
   logic            req_fire;
   logic            top;
   logic            trailer_ok;
   logic            emit;

   lcfp_decode #(
      .PANEL_COUNT  (PANEL_COUNT),
      .EFFECT_COUNT (EFFECT_COUNT),
      .MODE_COUNT   (MODE_COUNT)
   ) u_decode (
      .address  (address_ff),
      .red7     (red_ff),
      .green7   (green_ff),
      .blue7    (blue_ff),
      .white7   (white_ff),
      .top_bits (req_rx_byte[3:0]),
      .result   (dec)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_fire   = req_valid && req_ready;
   assign top        = req_rx_byte[7];
   assign trailer_ok = req_rx_byte[7:4] == 4'd0;
   assign emit       = req_fire && (phase_ff == PH_WHITE) && trailer_ok && dec.hit;

   always_comb begin
      phase_in   = phase_ff;
      address_in = address_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      white_in   = white_ff;
      if (req_fire) begin
         case (phase_ff)
            PH_IDLE: begin
               if (top) begin
                  address_in = req_rx_byte[6:0];
                  phase_in   = PH_ADDR;
               end
            end
            PH_ADDR, PH_RED, PH_GREEN, PH_BLUE: begin
               if (top) begin
                  address_in = req_rx_byte[6:0];
                  phase_in   = PH_ADDR;
               end else begin
                  if (phase_ff == PH_ADDR) red_in = req_rx_byte[6:0];
                  if (phase_ff == PH_RED) green_in = req_rx_byte[6:0];
                  if (phase_ff == PH_GREEN) blue_in = req_rx_byte[6:0];
                  if (phase_ff == PH_BLUE) white_in = req_rx_byte[6:0];
                  phase_in = phase_ff + 3'd1;
               end
            end
            PH_WHITE: begin
               // good trailer ends the frame; a top bit starts a new one
               if (trailer_ok) begin
                  phase_in = PH_IDLE;
               end else if (top) begin
                  address_in = req_rx_byte[6:0];
                  phase_in   = PH_ADDR;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = emit ? dec : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      address_ff <= address_in;
      red_ff     <= red_in;
      green_ff   <= green_in;
      blue_ff    <= blue_in;
      white_ff   <= white_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_target = rsp_ff.target;
   assign rsp_slot   = rsp_ff.slot;
   assign rsp_red    = rsp_ff.red;
   assign rsp_green  = rsp_ff.green;
   assign rsp_blue   = rsp_ff.blue;
   assign rsp_white  = rsp_ff.white;

   `LCFP_ASSERT_IMPLY(a_phase_legal, clock, reset, 1'b1, phase_ff <= PH_WHITE)
   `LCFP_ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready)
   `LCFP_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp_valid_ff && phase_ff == PH_IDLE)
   `LCFP_ASSERT_IMPLY(a_mode_no_color, clock, reset, rsp_valid_ff && rsp_ff.target == TGT_MODE, rsp_ff.red == 8'd0 && rsp_ff.white == 8'd0)

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// self-checking testbench for led_color_frame_parser: byte stream in, frame writes out
// predicts each write from the accepted bytes and compares it field by field
// depends on lcfp_pkg and the led_color_frame_parser rtl
`timescale 1ns / 1ps

module tb_top;
   import lcfp_pkg::*;

   localparam int PANEL_COUNT  = PANEL_COUNT_DEFAULT;
   localparam int EFFECT_COUNT = EFFECT_COUNT_DEFAULT;
   localparam int MODE_COUNT   = MODE_COUNT_DEFAULT;
   localparam int RANDOM_BYTES = 600;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_target;
   logic [3:0] rsp_slot;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic [7:0] rsp_white;

   // parser state mirrored by the predictor
   logic [2:0] frame_phase = PH_IDLE;
   logic [6:0] addr_hold   = '0;
   logic [6:0] red_hold    = '0;
   logic [6:0] green_hold  = '0;
   logic [6:0] blue_hold   = '0;
   logic [6:0] white_hold  = '0;

   lcfp_result_type pending_writes[$];

   int  error_count   = 0;
   int  bytes_sent    = 0;
   int  ignored_bytes = 0;
   int  panel_writes  = 0;
   int  effect_writes = 0;
   int  mode_writes   = 0;
   int  hold_cycles   = 0;
   bit  no_idle       = 1'b0;

   always #4 clock = ~clock;

   led_color_frame_parser #(
      .PANEL_COUNT  (PANEL_COUNT),
      .EFFECT_COUNT (EFFECT_COUNT),
      .MODE_COUNT   (MODE_COUNT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_target  (rsp_target),
      .rsp_slot    (rsp_slot),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .rsp_white   (rsp_white)
   );

   // mostly short gaps, a few long ones
   function automatic int idle_cycles();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic latch_address(input logic [7:0] b);
      addr_hold   = b[6:0];
      frame_phase = PH_ADDR;
   endtask

   task automatic decode_frame(input logic [7:0] trailer);
      lcfp_result_type w;
      w = '0;
      w.hit = 1'b1;
      frame_phase = PH_IDLE;
      if (addr_hold < PANEL_COUNT) begin
         w.target = TGT_PANEL;
         w.slot   = 4'(addr_hold);
      end else if (addr_hold >= ADDR_EFFECT_BASE &&
                   addr_hold < ADDR_EFFECT_BASE + EFFECT_COUNT) begin
         w.target = TGT_EFFECT;
         w.slot   = 4'(addr_hold - ADDR_EFFECT_BASE);
      end else if (addr_hold >= ADDR_MODE_BASE &&
                   addr_hold < ADDR_MODE_BASE + MODE_COUNT) begin
         w.target = TGT_MODE;
         w.slot   = 4'(addr_hold - ADDR_MODE_BASE);
      end else begin
         w.hit = 1'b0;
      end
      if (w.hit && w.target != TGT_MODE) begin
         w.red   = {trailer[0], red_hold};
         w.green = {trailer[1], green_hold};
         w.blue  = {trailer[2], blue_hold};
         w.white = {trailer[3], white_hold};
      end
      if (w.hit) pending_writes.push_back(w);
   endtask

   // advance the mirrored parser by one accepted request
   task automatic parse_byte(input logic [7:0] b);
      case (frame_phase)
         PH_IDLE: begin
            if (b[7]) latch_address(b);
            else ignored_bytes++;
         end
         PH_ADDR, PH_RED, PH_GREEN, PH_BLUE: begin
            if (b[7]) begin
               latch_address(b);
            end else begin
               case (frame_phase)
                  PH_ADDR:  red_hold   = b[6:0];
                  PH_RED:   green_hold = b[6:0];
                  PH_GREEN: blue_hold  = b[6:0];
                  default:  white_hold = b[6:0];
               endcase
               frame_phase = frame_phase + 3'd1;
            end
         end
         PH_WHITE: begin
            if (b[7:4] == 4'h0) decode_frame(b);
            else if (b[7]) latch_address(b);
            else frame_phase = PH_IDLE;
         end
         default: frame_phase = PH_IDLE;
      endcase
   endtask

   // valid stays high across back-to-back requests
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      parse_byte(b);
      bytes_sent++;
   endtask

   task automatic send_bytes(input logic [7:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic send_random_frame(input bit corrupt_allowed);
      logic [7:0] fb[6];
      logic [6:0] addr;
      int r;
      int pos;
      r = $urandom_range(0, 99);
      if (r < 40) addr = 7'($urandom_range(0, PANEL_COUNT - 1));
      else if (r < 60) addr = 7'($urandom_range(100, 100 + EFFECT_COUNT - 1));
      else if (r < 80) addr = 7'($urandom_range(120, 120 + MODE_COUNT - 1));
      else addr = 7'($urandom_range(0, 127));
      fb[0] = {1'b1, addr};
      for (int i = 1; i < 5; i++) fb[i] = {1'b0, 7'($urandom_range(0, 127))};
      fb[5] = {4'h0, 4'($urandom_range(0, 15))};
      if (corrupt_allowed && $urandom_range(0, 99) < 15) begin
         pos = $urandom_range(1, 5);
         if ($urandom_range(0, 1) == 0) fb[pos] = {1'b1, 7'($urandom_range(0, 127))};
         else fb[5] = {4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))};
      end
      foreach (fb[i]) send_byte(fb[i]);
   endtask

   // receiver side: random stalls, or a long hold when one is requested
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            n = hold_cycles;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            hold_cycles = 0;
            rsp_ready <= 1'b1;
         end else begin
            n = idle_cycles();
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      lcfp_result_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_writes.size() == 0) begin
            $error("unexpected write: target %0d slot %0d", rsp_target, rsp_slot);
            error_count++;
         end else begin
            w = pending_writes.pop_front();
            if (rsp_target !== w.target) begin
               $error("rsp_target: expected %0d, actual %0d", w.target, rsp_target);
               error_count++;
            end
            if (rsp_slot !== w.slot) begin
               $error("rsp_slot: expected %0d, actual %0d", w.slot, rsp_slot);
               error_count++;
            end
            if (rsp_red !== w.red) begin
               $error("rsp_red: expected 0x%02h, actual 0x%02h", w.red, rsp_red);
               error_count++;
            end
            if (rsp_green !== w.green) begin
               $error("rsp_green: expected 0x%02h, actual 0x%02h", w.green, rsp_green);
               error_count++;
            end
            if (rsp_blue !== w.blue) begin
               $error("rsp_blue: expected 0x%02h, actual 0x%02h", w.blue, rsp_blue);
               error_count++;
            end
            if (rsp_white !== w.white) begin
               $error("rsp_white: expected 0x%02h, actual 0x%02h", w.white, rsp_white);
               error_count++;
            end
            case (w.target)
               TGT_PANEL:  panel_writes++;
               TGT_EFFECT: effect_writes++;
               default:    mode_writes++;
            endcase
         end
      end
   end

   task automatic test_idle_noise();
      send_bytes('{8'h00, 8'h7F});
   endtask

   task automatic test_panel_extremes();
      send_bytes('{8'h80, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h0F});
   endtask

   // out-of-range address cut short by a mode address, then a full mode frame
   task automatic test_restart_mid_frame();
      send_bytes('{8'h90, 8'h01, 8'hFF, 8'h55, 8'h2A, 8'h01, 8'h7F, 8'h05});
   endtask

   // trailer with bit 7 set starts an effect frame, then a bad trailer drops one
   task automatic test_trailer_cases();
      send_bytes('{8'h8F, 8'h01, 8'h02, 8'h03, 8'h04, 8'hE4,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_bytes('{8'hEB, 8'h00, 8'h7F, 8'h00, 8'h7F, 8'h70});
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (40) send_random_frame(1'b1);
      no_idle = 1'b0;
   endtask

   task automatic test_receiver_hold();
      no_idle     = 1'b1;
      hold_cycles = 300;
      repeat (12) send_random_frame(1'b0);
      no_idle = 1'b0;
   endtask

   task automatic test_random_stream();
      int start;
      start = bytes_sent - ignored_bytes;
      while (bytes_sent - ignored_bytes - start < RANDOM_BYTES) begin
         if ($urandom_range(0, 99) < 75) begin
            send_random_frame(1'b1);
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_idle_noise();
      test_panel_extremes();
      test_restart_mid_frame();
      test_trailer_cases();
      test_back_to_back();
      test_receiver_hold();
      test_random_stream();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("sent %0d request bytes (%0d ignored while idle)", bytes_sent, ignored_bytes);
      $display("checked %0d panel, %0d effect and %0d mode writes",
               panel_writes, effect_writes, mode_writes);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/lcfp_pkg.sv
design/lcfp_decode.sv
design/led_color_frame_parser.sv
tb/sv/tb_top.sv
